>>> src/assert_macros.svh
// Assertion helpers for the glyph renderer. The clock is always "clock" and
// the synchronous reset "reset"; every check is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition at every clock edge
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed");

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLIES(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/sgtr_pkg.sv
`timescale 1ns / 1ps

package sgtr_pkg;

   // Font geometry
   localparam int GLYPH_ROWS     = 24;
   localparam int CHAR_COUNT     = 256;
   localparam int MAX_GLYPH_SIZE = 64;
   localparam int MIN_GLYPH_SIZE = 8;
   localparam int STORE_BITS     = 24;
   localparam int STORE_DEPTH    = CHAR_COUNT * GLYPH_ROWS;

   // Field widths
   localparam int OP_W       = 2;
   localparam int CODE_W     = 8;
   localparam int POS_W      = 16;
   localparam int ROW_IDX_W  = 5;
   localparam int WORD_W     = 32;
   localparam int SIZE_W     = 7;
   localparam int SCR_DIM_W  = 13;
   localparam int COLOR_W    = 16;
   localparam int MASK_W     = MAX_GLYPH_SIZE;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Stream packing
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 112;

   // Internal widths
   localparam int X_W    = $clog2(MAX_GLYPH_SIZE);
   localparam int W_W    = $clog2(GLYPH_ROWS);
   localparam int B_W    = $clog2(STORE_BITS);
   localparam int REM_W  = $clog2(MAX_GLYPH_SIZE + GLYPH_ROWS);
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int Q_MAX  = (GLYPH_ROWS + MIN_GLYPH_SIZE - 1) / MIN_GLYPH_SIZE;
   localparam int Q_W    = $clog2(Q_MAX + 1);
   localparam int PROD_W = $clog2(Q_MAX * MAX_GLYPH_SIZE + MAX_GLYPH_SIZE + GLYPH_ROWS);

   // Operation codes
   localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAW  = 2'd2;

   localparam logic [CODE_W-1:0] SPACE_CODE = 8'd32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GLYPH_SIZE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_COLOR   = 2'd3;

   // Commands from the controller
   typedef struct packed {
      logic map_step;
      logic do_load;
      logic do_start;
      logic do_space;
      logic do_setup;
      logic do_issue;
      logic do_advance;
   } cmd_type;

   // Status back to the controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            is_space;
      logic            size_written;
      logic            map_last;
      logic            row_last;
      logic            issue_ok;
   } status_type;

   typedef struct packed {
      logic [W_W-1:0]   idx;
      logic [REM_W-1:0] rem;
   } step_type;

   // One step of index = (GLYPH_ROWS * n) / size, kept as quotient and remainder
   function automatic step_type scale_step(input logic [W_W-1:0]    idx,
                                           input logic [REM_W-1:0]  rem,
                                           input logic [SIZE_W-1:0] size);
      logic [PROD_W-1:0] acc;
      logic [Q_W-1:0]    q;
      step_type          res;
      acc = PROD_W'(rem) + PROD_W'(GLYPH_ROWS);
      q   = '0;
      for (int k = 1; k <= Q_MAX; k++) begin
         if (acc >= PROD_W'(k) * PROD_W'(size)) begin
            q = Q_W'(k);
         end
      end
      res.idx = idx + W_W'(q);
      res.rem = REM_W'(acc - PROD_W'(q) * PROD_W'(size));
      return res;
   endfunction

endpackage

>>> src/sgtr_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgtr_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sgtr_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [sgtr_pkg::OP_W-1:0]         req_tuser,
   input  logic                              csr_write,
   input  logic [sgtr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sgtr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  sgtr_pkg::cmd_type                 cmd,
   output sgtr_pkg::status_type              status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sgtr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import sgtr_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0]   row_y;
      logic [POS_W-1:0]   start_x;
      logic [MASK_W-1:0]  mask;
      logic [COLOR_W-1:0] color;
      logic               last;
   } entry_type;

   // Request fields
   logic [CODE_W-1:0]    req_code;
   logic [POS_W-1:0]     req_pos_x;
   logic [POS_W-1:0]     req_pos_y;
   logic [ROW_IDX_W-1:0] req_row;
   logic [WORD_W-1:0]    req_word;

   assign req_code  = req_tdata[7:0];
   assign req_pos_x = req_tdata[23:8];
   assign req_pos_y = req_tdata[39:24];
   assign req_row   = req_tdata[44:40];
   assign req_word  = req_tdata[76:45];

   // Configuration registers
   logic [SIZE_W-1:0]    size_ff;
   logic [SCR_DIM_W-1:0] width_ff;
   logic [SCR_DIM_W-1:0] height_ff;
   logic [COLOR_W-1:0]   color_ff;
   logic [SIZE_W-1:0]    eff_size;

   // Cursor state
   logic [POS_W-1:0] cursor_ff, cursor_in;
   logic [POS_W-1:0] srow_ff, srow_in;

   // Column map build
   logic [X_W-1:0]   cx_ff;
   logic [W_W-1:0]   cw_ff;
   logic [REM_W-1:0] cr_ff;
   logic [W_W-1:0]   colmap_ff [MAX_GLYPH_SIZE];
   step_type         col_next;

   // Row walk
   logic [X_W-1:0]   y_ff;
   logic [W_W-1:0]   h_ff;
   logic [REM_W-1:0] r_ff;
   step_type         row_next;

   // Per-character setup
   logic [CODE_W-1:0]  code_ff;
   logic               blank_ff;
   logic signed [17:0] lo_ff, hi_ff, cur18;

   // Glyph store and read stage
   logic [STORE_BITS-1:0] store_mem [STORE_DEPTH];
   logic [STORE_BITS-1:0] rd_ff;
   logic [ADDR_W-1:0]     waddr, raddr;
   logic                  load_ok;

   // Row in flight between read and formation
   logic             if_valid_ff;
   logic [POS_W-1:0] if_row_y_ff;
   logic [POS_W-1:0] if_start_x_ff;
   logic             if_vis_ff;
   logic             if_last_ff;
   logic             if_blank_ff;

   // Output queue
   entry_type   q_ff [2];
   logic        head_ff;
   logic [1:0]  count_ff;
   logic        pop;
   logic        wr_idx;
   entry_type   push_entry;
   entry_type   q_head;

   logic [16:0]       row_sum;
   logic              row_vis;
   logic [SIZE_W-1:0] adv;
   logic [16:0]       adv_sum;
   logic [POS_W-1:0]  adv_sat;
   logic [MASK_W-1:0] form_mask;

   // Clamp the glyph size into the supported range
   always_comb begin
      if (size_ff < SIZE_W'(MIN_GLYPH_SIZE)) begin
         eff_size = SIZE_W'(MIN_GLYPH_SIZE);
      end else if (size_ff > SIZE_W'(MAX_GLYPH_SIZE)) begin
         eff_size = SIZE_W'(MAX_GLYPH_SIZE);
      end else begin
         eff_size = size_ff;
      end
   end

   assign col_next = scale_step(cw_ff, cr_ff, eff_size);
   assign row_next = scale_step(h_ff, r_ff, eff_size);

   // Cursor advance with saturation
   assign adv     = cmd.do_space ? (eff_size >> 1) : (eff_size - (eff_size >> 2));
   assign adv_sum = {cursor_ff[15], cursor_ff} + 17'(adv);
   always_comb begin
      if (adv_sum[16] != adv_sum[15]) begin
         adv_sat = adv_sum[16] ? 16'h8000 : 16'h7fff;
      end else begin
         adv_sat = adv_sum[15:0];
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      srow_in   = srow_ff;
      if (cmd.do_start) begin
         cursor_in = req_pos_x;
         srow_in   = req_pos_y;
      end else if (cmd.do_space || cmd.do_advance) begin
         cursor_in = adv_sat;
      end
   end

   // Row visibility uses the unwrapped row number
   assign row_sum = {srow_ff[15], srow_ff} + 17'(y_ff);
   assign row_vis = !row_sum[16] && (row_sum[15:0] < 16'(height_ff));

   assign cur18 = $signed({{2{cursor_ff[15]}}, cursor_ff});

   // Queue control
   assign pop    = rsp_tvalid && rsp_tready;
   assign wr_idx = head_ff + count_ff[0];
   assign q_head = q_ff[head_ff];

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= SIZE_W'(8);
         width_ff    <= SCR_DIM_W'(320);
         height_ff   <= SCR_DIM_W'(240);
         color_ff    <= COLOR_W'(65535);
         cursor_ff   <= '0;
         srow_ff     <= '0;
         cx_ff       <= '0;
         cw_ff       <= '0;
         cr_ff       <= '0;
         y_ff        <= '0;
         h_ff        <= '0;
         r_ff        <= '0;
         if_valid_ff <= 1'b0;
         head_ff     <= 1'b0;
         count_ff    <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               REG_GLYPH_SIZE:    size_ff   <= csr_wdata[SIZE_W-1:0];
               REG_SCREEN_WIDTH:  width_ff  <= csr_wdata[SCR_DIM_W-1:0];
               REG_SCREEN_HEIGHT: height_ff <= csr_wdata[SCR_DIM_W-1:0];
               REG_PIXEL_COLOR:   color_ff  <= csr_wdata[COLOR_W-1:0];
               default: ;
            endcase
         end
         cursor_ff <= cursor_in;
         srow_ff   <= srow_in;
         // Walk the column map while building, hold at zero otherwise
         if (cmd.map_step) begin
            cx_ff <= cx_ff + 1'b1;
            cw_ff <= col_next.idx;
            cr_ff <= col_next.rem;
         end else begin
            cx_ff <= '0;
            cw_ff <= '0;
            cr_ff <= '0;
         end
         // Restart the row walk at each character
         if (cmd.do_setup) begin
            y_ff <= '0;
            h_ff <= '0;
            r_ff <= '0;
         end else if (cmd.do_issue) begin
            y_ff <= y_ff + 1'b1;
            h_ff <= row_next.idx;
            r_ff <= row_next.rem;
         end
         if_valid_ff <= cmd.do_issue;
         if (pop) begin
            head_ff <= ~head_ff;
         end
         count_ff <= count_ff + 2'(if_valid_ff) - 2'(pop);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.map_step) begin
         colmap_ff[cx_ff] <= cw_ff;
      end
      if (cmd.do_setup) begin
         code_ff  <= req_code;
         blank_ff <= ({1'b0, req_code} >= 9'(CHAR_COUNT));
         lo_ff    <= 18'sd0 - cur18;
         hi_ff    <= $signed({5'b0, width_ff}) - cur18;
      end
      if (cmd.do_issue) begin
         if_row_y_ff   <= row_sum[15:0];
         if_start_x_ff <= cursor_ff;
         if_vis_ff     <= row_vis;
         if_last_ff    <= status.row_last;
         if_blank_ff   <= blank_ff;
      end
      if (if_valid_ff) begin
         q_ff[wr_idx] <= push_entry;
      end
   end

   // Glyph store: one write port for loads, one registered read for rows
   assign load_ok = (6'(req_row) < 6'(GLYPH_ROWS)) && ({1'b0, req_code} < 9'(CHAR_COUNT));
   assign waddr   = ADDR_W'(req_code) * ADDR_W'(GLYPH_ROWS) + ADDR_W'(req_row);
   assign raddr   = ADDR_W'(code_ff) * ADDR_W'(GLYPH_ROWS) + ADDR_W'(h_ff);

   always_ff @(posedge clock) begin
      if (cmd.do_load && load_ok) begin
         store_mem[waddr] <= req_word[WORD_W-1:WORD_W-STORE_BITS];
      end
      if (cmd.do_issue && !blank_ff) begin
         rd_ff <= store_mem[raddr];
      end
   end

   // Expand the stored row through the column map and clip horizontally
   always_comb begin
      form_mask = '0;
      for (int x = 0; x < MAX_GLYPH_SIZE; x++) begin
         if ((18'(x) >= lo_ff) && (18'(x) < hi_ff) && (SIZE_W'(x) < eff_size) &&
             (B_W'(colmap_ff[x]) < B_W'(STORE_BITS))) begin
            form_mask[x] = rd_ff[B_W'(STORE_BITS - 1) - B_W'(colmap_ff[x])];
         end
      end
   end

   always_comb begin
      push_entry.row_y   = if_row_y_ff;
      push_entry.start_x = if_start_x_ff;
      push_entry.mask    = (if_vis_ff && !if_blank_ff) ? form_mask : '0;
      push_entry.color   = color_ff;
      push_entry.last    = if_last_ff;
   end

   // Status
   assign status.op           = req_tuser;
   assign status.is_space     = (req_code == SPACE_CODE);
   assign status.size_written = csr_write && (csr_index == REG_GLYPH_SIZE);
   assign status.map_last     = (cx_ff == X_W'(MAX_GLYPH_SIZE - 1));
   assign status.row_last     = (SIZE_W'(y_ff) == eff_size - 1'b1);
   assign status.issue_ok     = ({1'b0, count_ff} + 3'(if_valid_ff)) <= (3'd1 + 3'(pop));

   // Result beat
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = {q_head.color, q_head.mask, q_head.start_x, q_head.row_y};
   assign rsp_tlast  = q_head.last;

   `ASSERT_ALWAYS(a_count_bound, count_ff <= 2'd2)
   `ASSERT_IMPLIES(a_push_room, if_valid_ff, count_ff != 2'd2)
   `ASSERT_IMPLIES(a_mask_in_size, rsp_tvalid, (q_head.mask >> eff_size) == '0)

endmodule

>>> src/sgtr_controller.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgtr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  sgtr_pkg::status_type status,
   output sgtr_pkg::cmd_type    cmd
);
   import sgtr_pkg::*;

   typedef enum logic [1:0] {
      ST_BUILD,
      ST_IDLE,
      ST_ROWS
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign accept     = req_tvalid && ready_ff;
   assign req_tready = ready_ff;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      ready_in = ready_ff;
      unique case (state_ff)
         ST_BUILD: begin
            // Restart the map walk from the top when the size changes mid-build
            if (!status.size_written) begin
               cmd.map_step = 1'b1;
               if (status.map_last) begin
                  state_in = ST_IDLE;
                  ready_in = 1'b1;
               end
            end
         end
         ST_IDLE: begin
            if (status.size_written) begin
               // New size: rebuild the column map
               state_in = ST_BUILD;
               ready_in = 1'b0;
            end else if (accept) begin
               unique case (status.op)
                  OP_LOAD:  cmd.do_load  = 1'b1;
                  OP_START: cmd.do_start = 1'b1;
                  OP_DRAW: begin
                     if (status.is_space) begin
                        cmd.do_space = 1'b1;
                     end else begin
                        cmd.do_setup = 1'b1;
                        state_in     = ST_ROWS;
                        ready_in     = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ROWS: begin
            // Issue one row read whenever the output buffer has room
            if (status.issue_ok) begin
               cmd.do_issue = 1'b1;
               if (status.row_last) begin
                  cmd.do_advance = 1'b1;
                  state_in       = ST_IDLE;
                  ready_in       = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_BUILD;
            ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BUILD;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   `ASSERT_IMPLIES(a_build_not_ready, state_ff == ST_BUILD, !ready_ff)
   `ASSERT_NEXT(a_advance_frees, cmd.do_advance, ready_ff)

endmodule

>>> src/scaled_glyph_text_renderer_unit.sv
`timescale 1ns / 1ps
// Scaled glyph text renderer.
// Request channel (req_*): one operation per beat, the kind in req_tuser:
// load one row of the glyph store, start a string at (pos_x, pos_y), or draw
// one character at the cursor. Loads, starts and spaces keep req_tready high.
// A drawn character of effective size S (glyph_size clamped to 8..64) gives
// S result beats on rsp_*, one per scaled row, rsp_tlast on the final row.
// The row sequencer issues one glyph store read per cycle while the output
// buffer has room. Each row read is registered, then written into the output
// buffer and offered from there; rows then follow one per cycle while the
// receiver keeps rsp_tready high.
// A two-entry output buffer parts the sides: when the receiver stalls the
// row reads pause, nothing is dropped, and a new request may be taken while
// the last rows of a character still wait in the buffer.
// After reset and after each glyph_size write the column map is rebuilt over
// all 64 columns with req_tready low. Reset restores register defaults, clears
// cursor and string row; the glyph store is not cleared and must be loaded before
// drawing. The user must write registers on csr_* only while idle (not enforced).
module scaled_glyph_text_renderer_unit (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: char_code[7:0], pos_x[23:8], pos_y[39:24], glyph_row[44:40],
   //            glyph_word[76:45], zero fill[79:77]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sgtr_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_tuser: operation[1:0]
   input  logic [sgtr_pkg::OP_W-1:0]       req_tuser,
   // rsp_tdata: row_y[15:0], start_x[31:16], pixel_mask[95:32], out_color[111:96]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sgtr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tlast: last_row
   output logic                            rsp_tlast,
   input  logic                            csr_write,
   input  logic [sgtr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sgtr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sgtr_pkg::*;

   cmd_type    cmd;
   status_type status;

   sgtr_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sgtr_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
